/* rtl/hsa_pkg.sv */
package hsa_pkg;

  // One incoming pixel, blue in the top byte.
  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_t;

  // One adjusted pixel.
  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } res_t;

  // Per-pixel values that travel alongside the two dividers.
  typedef struct packed {
    pix_t        pix;
    logic [8:0]  sum;    // max + min
    logic        neg;    // percent below zero: pull towards the lightness
    logic [16:0] scale;  // Q16 increment, or Q16 factor (100 + p) / 100 when neg
    logic        grey;   // max equals min: pass through
  } side_t;

  localparam logic [16:0] Q16_ONE   = 17'h10000;
  localparam logic [21:0] RECIP_25  = 22'd2684355;  // ceil(2^26 / 25)
  localparam logic signed [7:0] PCT_MAX = 8'sd100;
  localparam logic signed [7:0] PCT_MIN = -8'sd100;

  // floor(u * 65536 / 100) for u in 0..100, exact through the reciprocal of 25.
  function automatic logic [16:0] pct_to_q16(input logic [6:0] u);
    logic [28:0] prod;
    prod = {22'b0, u} * {7'b0, RECIP_25};
    return prod[28:12];
  endfunction

endpackage

/* rtl/hsa_front.sv */
module hsa_front import hsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  pix_t              in_pix,
  input  logic signed [7:0] sat_pct,
  output logic              vld_r,
  output side_t             side_r,
  output logic [7:0]        rem0_r,
  output logic [16:0]       lo_r,
  output logic [7:0]        den_r
);

  logic [7:0]        mx, mn, d;
  logic [8:0]        sum, den9;
  logic              grey;
  logic signed [7:0] pc, pu;
  logic              neg;
  side_t             side_nxt;

  always_comb begin
    mx = in_pix.blue_in;
    mn = in_pix.blue_in;
    if (in_pix.green_in > mx) mx = in_pix.green_in;
    if (in_pix.green_in < mn) mn = in_pix.green_in;
    if (in_pix.red_in > mx) mx = in_pix.red_in;
    if (in_pix.red_in < mn) mn = in_pix.red_in;
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    grey = (d == 8'd0);
    den9 = (sum < 9'd255) ? sum : 9'd510 - sum;

    priority if (sat_pct > PCT_MAX) begin
      pc = PCT_MAX;
    end else if (sat_pct < PCT_MIN) begin
      pc = PCT_MIN;
    end else begin
      pc = sat_pct;
    end
    neg = pc[7];
    pu  = neg ? pc + PCT_MAX : pc;

    side_nxt.pix   = in_pix;
    side_nxt.sum   = sum;
    side_nxt.neg   = neg;
    side_nxt.scale = pct_to_q16(pu[6:0]);
    side_nxt.grey  = grey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // The quotient d * 2^16 / den is below 2^17, so the divider starts with d >> 1.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      rem0_r <= {1'b0, d[7:1]};
      lo_r   <= {d[0], 16'b0};
      den_r  <= grey ? 8'd1 : den9[7:0];
    end
  end

endmodule

/* rtl/hsa_div.sv */
module hsa_div #(
  parameter int DEN_W = 8,
  parameter int Q_W   = 17,
  parameter int SB_W  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DEN_W-1:0] rem0,
  input  logic [Q_W-1:0]   lo,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb_in,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo,
  output logic [SB_W-1:0]  sb_out
);

  // Restoring division, one quotient bit per stage. The starting remainder
  // must be below the divisor.
  logic             vld_r [Q_W];
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   lo_r  [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_st
    logic             src_vld;
    logic [DEN_W-1:0] src_rem, src_den;
    logic [Q_W-1:0]   src_lo, src_quo;
    logic [SB_W-1:0]  src_sb;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_head
      assign src_vld = in_vld;
      assign src_rem = rem0;
      assign src_den = den;
      assign src_lo  = lo;
      assign src_quo = '0;
      assign src_sb  = sb_in;
    end else begin : g_link
      assign src_vld = vld_r[i-1];
      assign src_rem = rem_r[i-1];
      assign src_den = den_r[i-1];
      assign src_lo  = lo_r[i-1];
      assign src_quo = quo_r[i-1];
      assign src_sb  = sb_r[i-1];
    end

    assign trial = {src_rem, src_lo[Q_W-1]};
    assign ge    = (trial >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
        den_r[i] <= src_den;
        lo_r[i]  <= {src_lo[Q_W-2:0], 1'b0};
        quo_r[i] <= {src_quo[Q_W-2:0], ge};
        sb_r[i]  <= src_sb;
      end
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign quo     = quo_r[Q_W-1];
  assign sb_out  = sb_r[Q_W-1];

endmodule

/* rtl/hsa_back.sv */
module hsa_back import hsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [23:0] quo,
  input  side_t       side,
  output logic        out_vld_r,
  output res_t        out_r
);

  logic [23:0]        f, factor;
  logic [7:0]         ch [3];
  logic signed [10:0] diff [3];
  logic signed [35:0] prod_nxt [3];
  logic [24:0]        base_nxt [3];

  logic               vld_r;
  logic               grey_r;
  pix_t               pix_r;
  logic signed [35:0] prod_r [3];
  logic [24:0]        base_r [3];

  logic signed [36:0] w [3];
  logic [7:0]         res [3];

  // Multiply stage: (2c - sum) times the factor, both paths in one form.
  always_comb begin
    f      = quo - 24'h010000;
    factor = side.neg ? {7'b0, side.scale} : f;
    ch[0]  = side.pix.blue_in;
    ch[1]  = side.pix.green_in;
    ch[2]  = side.pix.red_in;
    for (int i = 0; i < 3; i++) begin
      diff[i]     = $signed({2'b0, ch[i], 1'b0}) - $signed({2'b0, side.sum});
      prod_nxt[i] = diff[i] * $signed({1'b0, factor});
      base_nxt[i] = side.neg ? {side.sum, 16'b0} : {ch[i], 17'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grey_r <= side.grey;
      pix_r  <= side.pix;
      prod_r <= prod_nxt;
      base_r <= base_nxt;
    end
  end

  // Sum, truncate the seventeen fraction bits and saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = $signed({12'b0, base_r[i]}) + $signed({prod_r[i][35], prod_r[i]});
      priority if (w[i][36]) begin
        res[i] = 8'd0;
      end else if (w[i][35:25] != 11'd0) begin
        res[i] = 8'd255;
      end else begin
        res[i] = w[i][24:17];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.blue_out  <= grey_r ? pix_r.blue_in  : res[0];
      out_r.green_out <= grey_r ? pix_r.green_in : res[1];
      out_r.red_out   <= grey_r ? pix_r.red_in   : res[2];
    end
  end

endmodule

/* rtl/hsl_saturation_adjust_core.sv */
// HSL saturation adjustment of a stream of 8-bit BGR pixels. Each pixel has
// its lightness (max + min) / 2 and HSL saturation worked out, and its
// channels are pushed away from the lightness for a percent of zero or more,
// or pulled towards it for a negative percent; grey pixels pass unchanged and
// results saturate to 0..255. The block takes one pixel every clock unless
// halted. It has one input stage, a 17-stage divider for the saturation, one
// stage choosing the divisor, a 24-stage divider forming the reciprocal
// factor, a multiply stage and a final add-and-clamp stage that is also the
// output register. The whole pipeline advances together; it halts only while
// a result is offered on out_valid and out_stall is high, and in_stall then
// follows it in the same cycle. The user must write saturation_percent through
// cfg_wr_en and cfg_wr_data only while no transaction is in flight; the block
// itself does not enforce this. Values outside -100..100 act as the nearest
// limit, and zero after reset passes pixels through.
module hsl_saturation_adjust_core import hsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_t              in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              out_data,
  input  logic              cfg_wr_en,
  input  logic signed [7:0] cfg_wr_data
);

  localparam int SB_W = $bits(side_t);

  logic signed [7:0] sat_pct_r;
  logic              adv;

  logic              f_vld;
  side_t             f_side;
  logic [7:0]        f_rem0, f_den;
  logic [16:0]       f_lo;

  logic              d1_vld;
  logic [16:0]       d1_quo;
  logic [SB_W-1:0]   d1_sb;
  side_t             d1_side;

  logic              a_vld_r;
  logic [16:0]       a_r, a_nxt;
  side_t             a_side_r;
  logic [17:0]       inc_plus_s;

  logic              d2_vld;
  logic [23:0]       d2_quo;
  logic [SB_W-1:0]   d2_sb;

  // The pipeline moves unless a finished transaction is held at the output.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_pct_r <= 8'sd0;
    end else if (cfg_wr_en) begin
      sat_pct_r <= cfg_wr_data;
    end
  end

  hsa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_pix  (in_data),
    .sat_pct (sat_pct_r),
    .vld_r   (f_vld),
    .side_r  (f_side),
    .rem0_r  (f_rem0),
    .lo_r    (f_lo),
    .den_r   (f_den)
  );

  // Saturation S = d * 2^16 / den, at most 2^16.
  hsa_div #(.DEN_W(8), .Q_W(17), .SB_W(SB_W)) u_div_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (f_vld),
    .rem0    (f_rem0),
    .lo      (f_lo),
    .den     (f_den),
    .sb_in   (f_side),
    .out_vld (d1_vld),
    .quo     (d1_quo),
    .sb_out  (d1_sb)
  );

  assign d1_side = side_t'(d1_sb);

  // Divisor alpha: S once the increment would take it to one or past, otherwise
  // one minus the increment. It stays at least 257, which keeps the
  // reciprocal below 2^24. Grey pixels and the negative path use one.
  always_comb begin
    inc_plus_s = {1'b0, d1_side.scale} + {1'b0, d1_quo};
    priority if (d1_side.neg || d1_side.grey) begin
      a_nxt = Q16_ONE;
    end else if (inc_plus_s >= {1'b0, Q16_ONE}) begin
      a_nxt = d1_quo;
    end else begin
      a_nxt = Q16_ONE - d1_side.scale;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= a_nxt;
      a_side_r <= d1_side;
    end
  end

  // Reciprocal 2^32 / alpha; the top of the dividend, 256, is the start value.
  hsa_div #(.DEN_W(17), .Q_W(24), .SB_W(SB_W)) u_div_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (a_vld_r),
    .rem0    (17'd256),
    .lo      (24'd0),
    .den     (a_r),
    .sb_in   (a_side_r),
    .out_vld (d2_vld),
    .quo     (d2_quo),
    .sb_out  (d2_sb)
  );

  hsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (d2_vld),
    .quo       (d2_quo),
    .side      (side_t'(d2_sb)),
    .out_vld_r (out_valid),
    .out_r     (out_data)
  );

endmodule

/* rtl/hsa_checker.sv */
module hsa_checker import hsa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pix_t              in_data,
  input logic              out_valid,
  input logic              out_stall,
  input res_t              out_data,
  input logic              cfg_wr_en,
  input logic signed [7:0] cfg_wr_data
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while held");

  // The input side waits exactly while a result is held.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held output");

  // Reset leaves no result on offer.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A new result appears only where the pipeline was moving just before it rose.
  a_rise_moved: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_stall))
    else $error("result appeared while the pipeline was halted");

endmodule

bind hsl_saturation_adjust_core hsa_checker u_hsa_checker (.*);

/* tb/sv/hsl_saturation_adjust_core_test.sv */
`timescale 1ns / 100ps

module hsl_saturation_adjust_core_test;
  import hsa_pkg::*;

  // Leave a margin beyond the pipeline depth after the last expected pixel
  // before a new percent is written or the run ends.
  localparam int PIPE_DEPTH = 45;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
  // A quiet spell this long, beyond any stall or idle burst the bench
  // draws, means the block has hung.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 1140;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pix_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;
  logic cfg_wr_en;
  logic signed [7:0] cfg_wr_data;

  hsl_saturation_adjust_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Pixels waiting to be sent, adjusted pixels still to arrive, and the
  // percent the predictor currently applies.
  pix_t pending_pixels[$];
  res_t expected_pixels[$];
  int signed model_percent;

  int mismatch_count;
  int sent_count;
  int received_count;
  int idle_count;
  bit idling_enabled;
  bit hung;

  int in_gap;
  int out_gap;

  // Truncate a Q32 value to an integer and clamp it to the pixel range.
  function automatic logic [7:0] clamp_q32(input longint signed v);
    longint signed whole;
    if (v < 0) begin
      return 8'd0;
    end
    whole = v >>> 32;
    return (whole > 255) ? 8'd255 : whole[7:0];
  endfunction

  // Predict the adjusted pixel for the percent currently in force.
  function automatic res_t adjust_pixel(input pix_t px);
    longint signed chan[3];
    longint signed hi, lo, sum, span, den, sat, pct, inc, alpha, fac, diff;
    logic [7:0] adj[3];
    res_t r;
    chan[0] = px.blue_in;
    chan[1] = px.green_in;
    chan[2] = px.red_in;
    hi = chan[0];
    lo = chan[0];
    for (int i = 1; i < 3; i++) begin
      if (chan[i] > hi) hi = chan[i];
      if (chan[i] < lo) lo = chan[i];
    end
    span = hi - lo;
    if (span == 0) begin
      for (int i = 0; i < 3; i++) adj[i] = chan[i][7:0];
    end else begin
      sum = hi + lo;
      den = (sum < 255) ? sum : (510 - sum);
      sat = (span * 65536) / den;
      pct = model_percent;
      if (pct > 100) pct = 100;
      if (pct < -100) pct = -100;
      if (pct >= 0) begin
        inc = (pct * 65536) / 100;
        alpha = (inc + sat >= 65536) ? sat : (65536 - inc);
        fac = (64'sd1 <<< 32) / alpha - 65536;
        for (int i = 0; i < 3; i++) begin
          diff = chan[i] * 65536 - sum * 32768;
          adj[i] = clamp_q32((chan[i] <<< 32) + diff * fac);
        end
      end else begin
        fac = ((100 + pct) * 65536) / 100;
        for (int i = 0; i < 3; i++) begin
          diff = chan[i] * 65536 - sum * 32768;
          adj[i] = clamp_q32(sum * 32768 * 65536 + diff * fac);
        end
      end
    end
    r.blue_out = adj[0];
    r.green_out = adj[1];
    r.red_out = adj[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0d, expected %0d (percent %0d, pixel %0d)",
             what, got, want, model_percent, received_count);
    mismatch_count++;
  endtask

  // Driver: on each falling edge either present the next pixel or idle for
  // a random burst. A pixel held under stall is left untouched.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_data <= pending_pixels.pop_front();
        in_valid <= 1'b1;
        if (idling_enabled && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, in bursts as well.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idling_enabled && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 16);
    end
  end

  // Monitor: predicts on each accepted input transaction and checks each
  // accepted output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(adjust_pixel(in_data));
        sent_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("MISMATCH unexpected pixel %h", out_data);
          mismatch_count++;
        end else begin
          res_t want;
          want = expected_pixels.pop_front();
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue", out_data.blue_out, want.blue_out);
          if (out_data.green_out !== want.green_out)
            report_mismatch("green", out_data.green_out, want.green_out);
          if (out_data.red_out !== want.red_out)
            report_mismatch("red", out_data.red_out, want.red_out);
        end
        received_count++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= HANG_LIMIT) hung = 1'b1;
    end
  end

  // Wait until every queued pixel is sent and checked, then let the
  // pipeline empty before the percent changes.
  task automatic drain;
    while ((pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
           && !hung) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Percent writes happen only with the pipeline empty.
  task automatic write_percent(input int signed pct);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pct[7:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_percent = $signed(pct[7:0]);
  endtask

  function automatic pix_t mk_pixel(input logic [7:0] b, input logic [7:0] g,
                                    input logic [7:0] r);
    pix_t p;
    p.blue_in = b;
    p.green_in = g;
    p.red_in = r;
    return p;
  endfunction

  // Mostly random pixels, with greys, near-greys and extremes mixed in.
  function automatic pix_t random_pixel;
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = 8'($urandom);
        return mk_pixel(v, v, v);
      end
      1: begin
        v = 8'($urandom_range(0, 254));
        return mk_pixel(v, v + 8'd1, v);
      end
      2: return mk_pixel(($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0,
                         ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0,
                         8'($urandom));
      default: return mk_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endfunction

  task automatic directed_pixels;
    pending_pixels.push_back(mk_pixel(0, 0, 0));
    pending_pixels.push_back(mk_pixel(255, 255, 255));
    pending_pixels.push_back(mk_pixel(128, 128, 128));
    pending_pixels.push_back(mk_pixel(255, 0, 0));
    pending_pixels.push_back(mk_pixel(0, 255, 0));
    pending_pixels.push_back(mk_pixel(0, 0, 255));
    pending_pixels.push_back(mk_pixel(255, 255, 0));
    pending_pixels.push_back(mk_pixel(0, 1, 0));
    pending_pixels.push_back(mk_pixel(254, 255, 255));
    pending_pixels.push_back(mk_pixel(127, 128, 127));
    pending_pixels.push_back(mk_pixel(200, 100, 50));
    pending_pixels.push_back(mk_pixel(10, 240, 130));
    pending_pixels.push_back(mk_pixel(170, 85, 85));
    pending_pixels.push_back(mk_pixel(85, 170, 170));
    pending_pixels.push_back(mk_pixel(1, 2, 3));
  endtask

  // Percents: extremes, zero, the out-of-range codes either side, and a
  // random code of any value in the first phase.
  int signed percent_plan[] = '{0, 100, -100, 127, -128, 1, -1, 50, -50, 101, -101, 99, 0};

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    model_percent = 0;
    idling_enabled = 1'b1;
    in_gap = 0;
    out_gap = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset value first: pixels should pass through untouched.
    directed_pixels();
    drain();
    foreach (percent_plan[i]) begin
      if (hung) break;
      write_percent(i == 0 ? $urandom_range(0, 255) : percent_plan[i]);
      directed_pixels();
      for (int n = 0; n < RANDOM_PIXELS / percent_plan.size(); n++)
        pending_pixels.push_back(random_pixel());
      // The final phase runs without any idling on either side.
      if (i == percent_plan.size() - 1) idling_enabled = 1'b0;
      drain();
    end

    if (hung) begin
      $display("end of test: mismatches");
      $finish;
    end
    $display("Covered %0d pixels over %0d percent settings, extremes and",
             received_count, percent_plan.size() + 1);
    $display("out-of-range codes included, with random stalls on both sides.");
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* hsl_saturation_adjust_core.f */
rtl/hsa_pkg.sv
rtl/hsa_front.sv
rtl/hsa_div.sv
rtl/hsa_back.sv
rtl/hsl_saturation_adjust_core.sv
rtl/hsa_checker.sv
tb/sv/hsl_saturation_adjust_core_test.sv
